// ===== rtl/core/url_percent_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// url_percent_decoder_assert
// Assertion macros for the URL percent decoder RTL, included by upd_queue.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Condition must never hold outside reset.
`define UPD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define UPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DIG  = 2'd2
	} phase_t;

	// Decoded results of one input word: one to three bytes.
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} pkt_t;

	function automatic logic upd_is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] upd_hex_nib(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded words, tracks the escape state and builds result packets.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          q_full,
	output logic          push,
	output upd_pkg::pkt_t push_pkt
);
	import upd_pkg::*;

	phase_t          phase_q, nxt_phase;
	logic [7:0]      held_q, nxt_held;
	logic            acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (acc) begin
			phase_q <= nxt_phase;
			held_q  <= nxt_held;
		end
	end

	always_comb begin
		logic [2:0]      n;
		logic [2:0][7:0] slot;
		logic            run_plain;
		logic            b_hex;
		n         = 3'd0;
		slot      = '0;
		run_plain = 1'b0;
		b_hex     = upd_is_hex(in_byte);
		nxt_phase = phase_q;
		nxt_held  = held_q;
		case (phase_q)
			PH_PCT: begin
				if (b_hex) begin
					nxt_phase = PH_DIG;
					nxt_held  = in_byte;
				end else begin
					slot[n[1:0]] = CH_PERCENT;
					n = n + 3'd1;
					run_plain = 1'b1;
				end
			end
			PH_DIG: begin
				if (b_hex) begin
					slot[n[1:0]] = {upd_hex_nib(held_q), upd_hex_nib(in_byte)};
					n = n + 3'd1;
					nxt_phase = PH_IDLE;
				end else begin
					slot[n[1:0]] = CH_PERCENT;
					n = n + 3'd1;
					slot[n[1:0]] = held_q;
					n = n + 3'd1;
					run_plain = 1'b1;
				end
				nxt_held = 8'd0;
			end
			default: run_plain = 1'b1;
		endcase
		if (run_plain) begin
			if (in_byte == CH_PERCENT) begin
				nxt_phase = PH_PCT;
			end else begin
				nxt_phase = PH_IDLE;
				slot[n[1:0]] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
				n = n + 3'd1;
			end
		end
		// flush a pending escape literally at end of string
		if (in_last) begin
			if (nxt_phase == PH_PCT) begin
				slot[n[1:0]] = CH_PERCENT;
				n = n + 3'd1;
			end else if (nxt_phase == PH_DIG) begin
				slot[n[1:0]] = CH_PERCENT;
				n = n + 3'd1;
				slot[n[1:0]] = nxt_held;
				n = n + 3'd1;
			end
			nxt_phase = PH_IDLE;
			nxt_held  = 8'd0;
		end
		push_pkt.cnt   = n[1:0];
		push_pkt.last  = in_last;
		push_pkt.bytes = slot;
		push           = acc && (n != 3'd0);
	end

endmodule

// ===== rtl/core/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue
// Short packet queue between the front and the back.
// ----------------------------------------------------------------------------
`include "url_percent_decoder_assert.svh"

module upd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upd_pkg::pkt_t push_pkt,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output upd_pkg::pkt_t head_pkt
);
	import upd_pkg::*;

	pkt_t           slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_pkt   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`UPD_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "push into full queue")
	`UPD_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && !head_valid, "pop from empty queue")
	`UPD_ASSERT_IMP(a_push_nonempty, clk, arst_n, push, push_pkt.cnt != 2'd0, "empty packet pushed")
	`UPD_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count did not advance")

endmodule

// ===== rtl/core/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back
// Serializes each queued packet into output words, one byte per handshake.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  upd_pkg::pkt_t head_pkt,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       at_end;
	logic       take;

	assign at_end    = (idx_q == head_pkt.cnt - 2'd1);
	assign out_valid = head_valid;
	assign out_byte  = head_pkt.bytes[idx_q];
	assign out_last  = head_pkt.last && at_end;
	assign take      = out_valid && out_ready;
	assign pop       = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			// advance within the packet, restart on the next one
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Decodes a URL-encoded byte stream: '+' to space, '%XX' to its byte.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one encoded word (in_byte, in_last);
// output channel out_valid/out_ready carries one decoded word (out_byte,
// out_last). in_last marks the end of a string; out_last marks its final
// decoded word.
// Accepted words are registered into the packet queue. An input word yields
// zero to three results: '%' and a first hex digit yield none, a malformed
// escape yields up to three. Throughput: one input word per cycle unless
// the queue is full, one output word per cycle unless out_ready is low; the
// output side sets the pace, so a word with n results takes n handshakes.
// A four-entry packet queue sits between the front (escape tracking) and the
// back (serializer), so input keeps flowing while results wait.
// Reset clears the escape state and the queue; no results are pending.
// When the receiver stalls, the queue fills and in_ready drops once all four
// entries hold results.
// ----------------------------------------------------------------------------
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import upd_pkg::*;

	logic push, pop, q_full, head_valid;
	pkt_t push_pkt, head_pkt;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_pkt (push_pkt)
	);

	upd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_pkt   (head_pkt)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pkt   (head_pkt),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule
